@@ rtl/core/rotate_letterbox_scaler_address_unit_macros.svh @@
// Assertion macros used by the checker file of the address unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ROTATE_LETTERBOX_SCALER_ADDRESS_UNIT_MACROS_SVH
`define ROTATE_LETTERBOX_SCALER_ADDRESS_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RLSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define RLSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rlsa_pkg.sv @@
// Package of the rotate and letterbox scaler address unit.
// Holds sizes, register indexes, reset values and the transaction types.
// Depends on nothing.
package rlsa_pkg;

	localparam int COORD_BITS = 12;
	localparam int SRC_WIDTH  = 256;
	localparam int SRC_HEIGHT = 192;
	localparam int IDX_BITS   = 16;

	localparam int SRC_MAX   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int QUOT_BITS = $clog2(SRC_MAX);
	localparam int REM_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS = COORD_BITS + QUOT_BITS;
	localparam int IDXW      = 2 * QUOT_BITS + 1;

	localparam int SDIM_BITS = $clog2(SRC_MAX + 1);
	localparam int GDIV_BITS = COORD_BITS + SDIM_BITS;

	// Reciprocals of the source dimensions, exact for every GDIV_BITS wide dividend.
	localparam int     RCP_SHIFT = GDIV_BITS + SDIM_BITS;
	localparam longint RCP_W_VAL = ((longint'(1) << RCP_SHIFT) + longint'(SRC_WIDTH) - 1)
		/ longint'(SRC_WIDTH);
	localparam longint RCP_H_VAL = ((longint'(1) << RCP_SHIFT) + longint'(SRC_HEIGHT) - 1)
		/ longint'(SRC_HEIGHT);
	localparam int     RCP_BITS  = $clog2(((RCP_W_VAL > RCP_H_VAL) ? RCP_W_VAL : RCP_H_VAL) + 1);
	localparam int     RCP_PROD_BITS = GDIV_BITS + RCP_BITS;

	localparam logic [RCP_BITS-1:0] RCP_W = RCP_BITS'(RCP_W_VAL);
	localparam logic [RCP_BITS-1:0] RCP_H = RCP_BITS'(RCP_H_VAL);

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = COORD_BITS;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATE_LEFT  = CFG_IDX_BITS'(2);

	localparam logic [COORD_BITS-1:0] RST_PANEL_WIDTH  = COORD_BITS'(480);
	localparam logic [COORD_BITS-1:0] RST_PANEL_HEIGHT = COORD_BITS'(800);

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t phys_x;
		coord_t phys_y;
	} pix_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] source_index;
		logic                blank;
	} addr_t;

	typedef struct packed {
		coord_t panel_width;
		coord_t panel_height;
		logic   rotate_left;
	} cfg_t;

	typedef struct packed {
		coord_t content_w;
		coord_t content_h;
		coord_t offset_x;
		coord_t offset_y;
	} geom_t;

	typedef struct packed {
		logic   blank;
		coord_t pos_x;
		coord_t pos_y;
	} cls_t;

endpackage

@@ rtl/core/rlsa_geom.sv @@
// Content geometry sequencer: content size and centering offsets of the fitted image.
// Divides by the source dimensions through reciprocal multiplication; depends on rlsa_pkg.
module rlsa_geom (
	input  logic           clk,
	input  logic           arst_n,
	input  rlsa_pkg::cfg_t cfg,
	input  logic           restart,
	output rlsa_pkg::geom_t geom,
	output logic           ready
);
	import rlsa_pkg::*;

	typedef enum logic [2:0] {G_LOAD, G_DIV_H, G_FIT, G_DIV_W, G_OFFS, G_DONE} state_t;

	state_t                    state_q;
	logic [GDIV_BITS-1:0]      num_q;
	logic [GDIV_BITS-1:0]      quo_q;
	logic [RCP_BITS-1:0]       rcp;
	logic [RCP_PROD_BITS-1:0]  prod;
	logic [GDIV_BITS-1:0]      quo;
	geom_t                     geom_q;

	always_comb begin
		rcp  = (state_q == G_DIV_W) ? RCP_H : RCP_W;
		prod = RCP_PROD_BITS'(num_q) * RCP_PROD_BITS'(rcp);
		quo  = GDIV_BITS'(prod >> RCP_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_LOAD;
			num_q   <= '0;
			quo_q   <= '0;
			geom_q  <= '0;
		end else if (restart) begin
			state_q <= G_LOAD;
		end else begin
			unique case (state_q)
				G_LOAD: begin
					num_q   <= GDIV_BITS'(cfg.panel_height) * GDIV_BITS'(SRC_HEIGHT);
					state_q <= G_DIV_H;
				end
				G_DIV_H: begin
					quo_q   <= quo;
					state_q <= G_FIT;
				end
				G_FIT: begin
					if (quo_q > GDIV_BITS'(cfg.panel_width)) begin
						geom_q.content_h <= cfg.panel_width;
						num_q   <= GDIV_BITS'(cfg.panel_width) * GDIV_BITS'(SRC_WIDTH);
						state_q <= G_DIV_W;
					end else begin
						geom_q.content_w <= cfg.panel_height;
						geom_q.content_h <= quo_q[COORD_BITS-1:0];
						state_q <= G_OFFS;
					end
				end
				G_DIV_W: begin
					geom_q.content_w <= quo[COORD_BITS-1:0];
					state_q <= G_OFFS;
				end
				G_OFFS: begin
					geom_q.offset_x <= (cfg.panel_height - geom_q.content_w) >> 1;
					geom_q.offset_y <= (cfg.panel_width - geom_q.content_h) >> 1;
					state_q <= G_DONE;
				end
				G_DONE: begin
				end
				default: begin
					state_q <= G_LOAD;
				end
			endcase
		end
	end

	assign geom  = geom_q;
	assign ready = (state_q == G_DONE);

endmodule

@@ rtl/core/rlsa_front.sv @@
// Front end: accepts pixel transactions, rotates them into the logical frame
// and classifies them against the panel and content area; depends on rlsa_pkg.
module rlsa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  rlsa_pkg::pix_t  pix,
	input  rlsa_pkg::cfg_t  cfg,
	input  rlsa_pkg::geom_t geom,
	input  logic            geom_ready,
	output logic            push_valid,
	input  logic            push_ready,
	output rlsa_pkg::cls_t  push_data
);
	import rlsa_pkg::*;

	logic   valid_s1;
	logic   oob_s1;
	coord_t lx_s1;
	coord_t ly_s1;
	coord_t dx;
	coord_t dy;
	logic   in_x;
	logic   in_y;

	assign pix_ready = geom_ready && (!valid_s1 || push_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || push_ready) begin
			valid_s1 <= pix_valid && pix_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			oob_s1 <= (pix.phys_x >= cfg.panel_width) || (pix.phys_y >= cfg.panel_height);
			if (cfg.rotate_left) begin
				lx_s1 <= cfg.panel_height - COORD_BITS'(1) - pix.phys_y;
				ly_s1 <= pix.phys_x;
			end else begin
				lx_s1 <= pix.phys_y;
				ly_s1 <= cfg.panel_width - COORD_BITS'(1) - pix.phys_x;
			end
		end
	end

	always_comb begin
		dx   = lx_s1 - geom.offset_x;
		dy   = ly_s1 - geom.offset_y;
		in_x = (lx_s1 >= geom.offset_x) && (dx < geom.content_w);
		in_y = (ly_s1 >= geom.offset_y) && (dy < geom.content_h);
		push_data.blank = oob_s1 || !in_x || !in_y;
		push_data.pos_x = dx;
		push_data.pos_y = dy;
	end

	assign push_valid = valid_s1;

endmodule

@@ rtl/core/rlsa_fifo.sv @@
// Short queue of classified transactions between the front and back ends.
// Depends on rlsa_pkg for the entry type and depth.
module rlsa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rlsa_pkg::cls_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rlsa_pkg::cls_t pop_data
);
	import rlsa_pkg::*;

	cls_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS:0] wr_q;
	logic [FIFO_PTR_BITS:0] rd_q;
	logic                 full;
	logic                 empty;

	assign full  = (wr_q[FIFO_PTR_BITS] != rd_q[FIFO_PTR_BITS])
		&& (wr_q[FIFO_PTR_BITS-1:0] == rd_q[FIFO_PTR_BITS-1:0]);
	assign empty = (wr_q == rd_q);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = mem_q[rd_q[FIFO_PTR_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			mem_q[wr_q[FIFO_PTR_BITS-1:0]] <= push_data;
		end
	end

endmodule

@@ rtl/core/rlsa_back.sv @@
// Back end: pipelined restoring dividers for both axes, one quotient bit per stage,
// then the source index and the output register; depends on rlsa_pkg.
module rlsa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  rlsa_pkg::cls_t  pop_data,
	input  rlsa_pkg::geom_t geom,
	output logic            addr_valid,
	input  logic            addr_ready,
	output rlsa_pkg::addr_t addr
);
	import rlsa_pkg::*;

	typedef struct packed {
		logic                 blank;
		logic [REM_BITS-1:0]  rem_x;
		logic [QUOT_BITS-1:0] dq_x;
		logic [REM_BITS-1:0]  rem_y;
		logic [QUOT_BITS-1:0] dq_y;
	} stage_t;

	function automatic stage_t div_step(stage_t s, coord_t span_x, coord_t span_y);
		logic [REM_BITS-1:0] sh_x;
		logic [REM_BITS-1:0] sh_y;
		logic                tx;
		logic                ty;
		stage_t              r;
		sh_x   = {s.rem_x[REM_BITS-2:0], s.dq_x[QUOT_BITS-1]};
		sh_y   = {s.rem_y[REM_BITS-2:0], s.dq_y[QUOT_BITS-1]};
		tx     = sh_x >= {1'b0, span_x};
		ty     = sh_y >= {1'b0, span_y};
		r      = s;
		r.rem_x = tx ? sh_x - {1'b0, span_x} : sh_x;
		r.rem_y = ty ? sh_y - {1'b0, span_y} : sh_y;
		r.dq_x  = {s.dq_x[QUOT_BITS-2:0], tx};
		r.dq_y  = {s.dq_y[QUOT_BITS-2:0], ty};
		return r;
	endfunction

	stage_t                div_s [QUOT_BITS+1];
	stage_t                step_s [QUOT_BITS];
	logic [QUOT_BITS:0]    vld_s;
	stage_t                load;
	logic [PROD_BITS-1:0]  prod_x;
	logic [PROD_BITS-1:0]  prod_y;
	logic                  adv;
	logic                  addr_valid_q;
	addr_t                 addr_q;

	assign adv       = !addr_valid_q || addr_ready;
	assign pop_ready = adv;

	always_comb begin
		prod_x     = PROD_BITS'(pop_data.pos_x) * PROD_BITS'(SRC_WIDTH);
		prod_y     = PROD_BITS'(pop_data.pos_y) * PROD_BITS'(SRC_HEIGHT);
		load.blank = pop_data.blank;
		load.rem_x = REM_BITS'(prod_x[PROD_BITS-1:QUOT_BITS]);
		load.dq_x  = prod_x[QUOT_BITS-1:0];
		load.rem_y = REM_BITS'(prod_y[PROD_BITS-1:QUOT_BITS]);
		load.dq_y  = prod_y[QUOT_BITS-1:0];
		for (int k = 0; k < QUOT_BITS; k++) begin
			step_s[k] = div_step(div_s[k], geom.content_w, geom.content_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s        <= '0;
			addr_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s        <= {vld_s[QUOT_BITS-1:0], pop_valid};
			addr_valid_q <= vld_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= load;
			for (int k = 0; k < QUOT_BITS; k++) begin
				div_s[k+1] <= step_s[k];
			end
			addr_q.blank <= div_s[QUOT_BITS].blank;
			if (div_s[QUOT_BITS].blank) begin
				addr_q.source_index <= '0;
			end else begin
				addr_q.source_index <= IDX_BITS'(IDXW'(div_s[QUOT_BITS].dq_y)
					* IDXW'(SRC_WIDTH) + IDXW'(div_s[QUOT_BITS].dq_x));
			end
		end
	end

	assign addr_valid = addr_valid_q;
	assign addr       = addr_q;

endmodule

@@ rtl/core/rotate_letterbox_scaler_address_unit.sv @@
// Rotate and letterbox scaler address unit: top level with configuration registers.
// One transaction per cycle when neither the address output nor a geometry pass stalls the input.
// The per-axis divider pipelines retire one quotient bit per stage and hold when the
// address output stalls. Reset loads 480 x 800, rotate right; reset and every register
// write start a geometry pass (load, height division, fit, offsets; a width division too
// when the content is fitted to the frame height), during which pix_ready is low.
module rotate_letterbox_scaler_address_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  rlsa_pkg::pix_t                      pix,
	output logic                                addr_valid,
	input  logic                                addr_ready,
	output rlsa_pkg::addr_t                     addr,
	input  logic                                cfg_we,
	input  logic [rlsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rlsa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import rlsa_pkg::*;

	cfg_t  cfg_q;
	geom_t geom;
	logic  geom_ready;
	logic  push_valid;
	logic  push_ready;
	cls_t  push_data;
	logic  pop_valid;
	logic  pop_ready;
	cls_t  pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width  <= RST_PANEL_WIDTH;
			cfg_q.panel_height <= RST_PANEL_HEIGHT;
			cfg_q.rotate_left  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PANEL_WIDTH:  cfg_q.panel_width  <= cfg_data[COORD_BITS-1:0];
				CFG_PANEL_HEIGHT: cfg_q.panel_height <= cfg_data[COORD_BITS-1:0];
				CFG_ROTATE_LEFT:  cfg_q.rotate_left  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rlsa_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (cfg_we),
		.geom    (geom),
		.ready   (geom_ready)
	);

	rlsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.cfg        (cfg_q),
		.geom       (geom),
		.geom_ready (geom_ready),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rlsa_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rlsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.geom       (geom),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr)
	);

endmodule

@@ rtl/core/rlsa_checker.sv @@
// Port-level checker of the address unit, bound to the top level.
// Depends on rlsa_pkg and the assertion macro header.
`include "rotate_letterbox_scaler_address_unit_macros.svh"

module rlsa_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            pix_valid,
	input logic            pix_ready,
	input rlsa_pkg::pix_t  pix,
	input logic            addr_valid,
	input logic            addr_ready,
	input rlsa_pkg::addr_t addr,
	input logic            cfg_we
);
	import rlsa_pkg::*;

	`RLSA_ASSERT(a_blank_index_zero, addr_valid && addr.blank |-> addr.source_index == '0, "A blank index is set.")
	`RLSA_ASSERT_NEXT(a_cfg_stalls_input, cfg_we, !pix_ready, "Pixels are taken during geometry.")
	`RLSA_ASSERT_NEXT(a_pix_held, pix_valid && !pix_ready, pix_valid && $stable(pix), "A waiting pixel moved.")
	`RLSA_ASSERT_NEXT(a_addr_held, addr_valid && !addr_ready, addr_valid && $stable(addr), "A held address moved.")

endmodule

bind rotate_letterbox_scaler_address_unit rlsa_checker u_rlsa_checker (.*);
